[design/dsi_lp_packet_framer_defines.svh]
// Assertion macros for the DSI low-power packet framer.
`ifndef DSI_LP_PACKET_FRAMER_DEFINES_SVH
`define DSI_LP_PACKET_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on aclk outside reset
`define DSI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("framer check failed");
// next-cycle implication, checked on aclk outside reset
`define DSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("framer check failed");
`else
`define DSI_ASSERT_IMP(label, ante, cons)
`define DSI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[design/dsilp_pkg.sv]
// Shared constants, types and helper functions for the DSI low-power packet framer.
package dsilp_pkg;

    // command codes on the input channel
    localparam logic [1:0] CMD_SHORT   = 2'd0;
    localparam logic [1:0] CMD_LONG    = 2'd1;
    localparam logic [1:0] CMD_PAYLOAD = 2'd2;

    localparam logic [7:0]  ESC_BYTE = 8'hE1;
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0]  TYPE_DCS = 8'h39;
    localparam logic [7:0]  TYPE_GEN = 8'h29;

    localparam logic [23:0] ECC_MASKS [6] = '{
        24'hF12CB7, 24'hF2555B, 24'h749A6D, 24'hB8E38E, 24'hDF03F0, 24'hEFFC00
    };

    // default depth of the job queue between front and back
    localparam int FIFO_DEPTH_DEF = 4;

    // one job handed from the front end to the byte serializer
    typedef struct packed {
        logic       is_hdr;       // header job: escape byte plus four header bytes
        logic       end_on_last;  // packet_end goes out with the final byte
        logic       crc_follow;   // two CRC bytes close the job
        logic [7:0] b0;           // reversed type, or reversed payload byte
        logic [7:0] b1;           // reversed word0
        logic [7:0] b2;           // reversed word1, or zero for a long header
        logic [7:0] b3;           // reversed ECC
        logic [7:0] crc_lo;       // reversed CRC low byte
        logic [7:0] crc_hi;       // reversed CRC high byte
    } job_t;

    function automatic logic [7:0] rev8(input logic [7:0] x);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = x[i];
        end
        return r;
    endfunction

    function automatic logic [5:0] header_ecc(input logic [23:0] hdr);
        logic [5:0] e;
        for (int i = 0; i < 6; i++) begin
            e[i] = ^(hdr & ECC_MASKS[i]);
        end
        return e;
    endfunction

    // reflected CRC-16, data LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic [7:0]  d;
        c = crc;
        d = b;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

[design/dsilp_fifo.sv]
// Short job queue between the framer front end and the byte serializer.
module dsilp_fifo import dsilp_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_en,
    input  job_t wr_data,
    output logic wr_ready,
    input  logic rd_en,
    output job_t rd_data,
    output logic rd_valid
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/dsilp_front.sv]
// Front end: accepts command words, tracks payload count and CRC, builds jobs.
module dsilp_front import dsilp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_data_type,
    input  logic [7:0] s_word0,
    input  logic [7:0] s_word1,
    input  logic       s_is_dcs,
    input  logic [7:0] s_payload_byte,
    input  logic       q_ready,
    output logic       q_push,
    output job_t       q_job,
    output logic       rem_zero
);

    logic        crc_enable_reg;
    logic [7:0]  remaining_reg, remaining_next;
    logic [15:0] crc_reg, crc_next;

    logic        accept;
    logic        make_job;
    logic [7:0]  hdr_type;
    logic [7:0]  hdr_w1;
    logic [5:0]  ecc;
    logic [15:0] crc_payload;
    logic [15:0] crc_val;
    logic [15:0] crc_send;

    assign s_ready  = q_ready;
    assign accept   = s_valid && s_ready;
    assign q_push   = accept && make_job;
    assign rem_zero = (remaining_reg == '0);

    assign hdr_type    = (s_cmd == CMD_LONG) ? (s_is_dcs ? TYPE_DCS : TYPE_GEN) : s_data_type;
    assign hdr_w1      = (s_cmd == CMD_LONG) ? 8'h00 : s_word1;
    assign ecc         = header_ecc({hdr_w1, s_word0, hdr_type});
    assign crc_payload = crc_byte(crc_reg, s_payload_byte);
    assign crc_val     = (s_cmd == CMD_LONG) ? CRC_INIT : crc_payload;
    assign crc_send    = crc_enable_reg ? crc_val : 16'h0000;

    // classify the word and build the job
    always_comb begin
        make_job       = 1'b0;
        remaining_next = remaining_reg;
        crc_next       = crc_reg;
        q_job.is_hdr      = 1'b1;
        q_job.end_on_last = 1'b0;
        q_job.crc_follow  = 1'b0;
        q_job.b0          = rev8(hdr_type);
        q_job.b1          = rev8(s_word0);
        q_job.b2          = rev8(hdr_w1);
        q_job.b3          = rev8({2'b00, ecc});
        q_job.crc_lo      = rev8(crc_send[7:0]);
        q_job.crc_hi      = rev8(crc_send[15:8]);
        case (s_cmd)
            CMD_SHORT: begin
                make_job          = 1'b1;
                remaining_next    = '0;
                q_job.end_on_last = 1'b1;
            end
            CMD_LONG: begin
                make_job          = 1'b1;
                remaining_next    = s_word0;
                crc_next          = CRC_INIT;
                q_job.crc_follow  = (s_word0 == '0);
                q_job.end_on_last = (s_word0 == '0);
            end
            CMD_PAYLOAD: begin
                // stray bytes outside a payload are dropped
                if (!rem_zero) begin
                    make_job          = 1'b1;
                    remaining_next    = remaining_reg - 1'b1;
                    crc_next          = crc_payload;
                    q_job.is_hdr      = 1'b0;
                    q_job.b0          = rev8(s_payload_byte);
                    q_job.crc_follow  = (remaining_reg == 8'd1);
                    q_job.end_on_last = (remaining_reg == 8'd1);
                end
            end
            default: begin
                make_job = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_enable_reg <= 1'b0;
            remaining_reg  <= '0;
            crc_reg        <= CRC_INIT;
        end else begin
            if (cfg_wr_en) begin
                crc_enable_reg <= cfg_wr_data;
            end
            if (accept) begin
                remaining_reg <= remaining_next;
                crc_reg       <= crc_next;
            end
        end
    end

endmodule

[design/dsilp_back.sv]
// Back end: walks each job byte by byte into the output register.
module dsilp_back import dsilp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_packet_end,
    output logic       m_last_of_run
);

    job_t       cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg;
    logic       m_end_reg;
    logic       m_last_reg;

    logic       load;
    logic       is_last;
    logic       cur_free;
    logic [2:0] last_idx;
    logic [7:0] sel_byte;

    assign m_valid       = m_valid_reg;
    assign m_tx_byte     = m_byte_reg;
    assign m_packet_end  = m_end_reg;
    assign m_last_of_run = m_last_reg;

    // output register takes a new word when empty or being drained
    assign load     = !m_valid_reg || m_ready;
    assign last_idx = cur_reg.is_hdr ? (cur_reg.crc_follow ? 3'd6 : 3'd4)
                                     : (cur_reg.crc_follow ? 3'd2 : 3'd0);
    assign is_last  = (idx_reg == last_idx);
    assign cur_free = !cur_valid_reg || (load && is_last);
    assign q_pop    = cur_free && q_valid;

    // byte at the current position of the job
    always_comb begin
        if (cur_reg.is_hdr) begin
            case (idx_reg)
                3'd0:    sel_byte = ESC_BYTE;
                3'd1:    sel_byte = cur_reg.b0;
                3'd2:    sel_byte = cur_reg.b1;
                3'd3:    sel_byte = cur_reg.b2;
                3'd4:    sel_byte = cur_reg.b3;
                3'd5:    sel_byte = cur_reg.crc_lo;
                default: sel_byte = cur_reg.crc_hi;
            endcase
        end else begin
            case (idx_reg)
                3'd0:    sel_byte = cur_reg.b0;
                3'd1:    sel_byte = cur_reg.crc_lo;
                default: sel_byte = cur_reg.crc_hi;
            endcase
        end
    end

    // job sequencing
    always_comb begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        m_valid_next   = m_valid_reg;
        if (load) begin
            m_valid_next = cur_valid_reg;
        end
        if (cur_free) begin
            cur_valid_next = q_valid;
            idx_next       = '0;
        end else if (load) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_job;
        end
        if (load && cur_valid_reg) begin
            m_byte_reg <= sel_byte;
            m_end_reg  <= is_last && cur_reg.end_on_last;
            m_last_reg <= is_last;
        end
    end

endmodule

[design/dsi_lp_packet_framer.sv]
// Top level of the DSI low-power packet framer.
// Input channel (s_valid/s_ready): one command word per handshake. s_cmd 0 frames
// a short packet, 1 a long packet header (length in s_word0), 2 a payload byte.
// Output channel (m_valid/m_ready): one lane byte per word, with m_packet_end on
// the final byte of a packet and m_last_of_run on the final byte of each command.
// Configuration: cfg_wr_en writes cfg_wr_data into crc_enable at once (reset 0,
// zero CRC bytes); write it only while the framer is idle.
// The first byte of a command passes through the job queue, the current-job register
// and the output register. The serializer sends one byte per cycle while m_ready is
// high and jobs are queued; a header is 5 bytes (7 with a trailing CRC), a payload
// byte 1 (3 on the last). The serializer rate sets sustained input rate; the front end
// takes one command per cycle as long as the job queue (FIFO_DEPTH entries) has room.
// A stalled receiver holds the current byte; the queue then fills and s_ready drops.
// Synchronous reset empties the queue and output register, clears the payload count,
// sets the CRC to 0xFFFF and crc_enable to 0.
`include "dsi_lp_packet_framer_defines.svh"

module dsi_lp_packet_framer import dsilp_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_data_type,
    input  logic [7:0] s_word0,
    input  logic [7:0] s_word1,
    input  logic       s_is_dcs,
    input  logic [7:0] s_payload_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_packet_end,
    output logic       m_last_of_run
);

    logic fifo_push;
    logic fifo_ready;
    logic fifo_pop;
    logic fifo_valid;
    job_t push_job;
    job_t head_job;
    logic rem_zero;

    dsilp_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_data_type    (s_data_type),
        .s_word0        (s_word0),
        .s_word1        (s_word1),
        .s_is_dcs       (s_is_dcs),
        .s_payload_byte (s_payload_byte),
        .q_ready        (fifo_ready),
        .q_push         (fifo_push),
        .q_job          (push_job),
        .rem_zero       (rem_zero)
    );

    dsilp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (fifo_push),
        .wr_data  (push_job),
        .wr_ready (fifo_ready),
        .rd_en    (fifo_pop),
        .rd_data  (head_job),
        .rd_valid (fifo_valid)
    );

    dsilp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (fifo_valid),
        .q_job         (head_job),
        .q_pop         (fifo_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_packet_end  (m_packet_end),
        .m_last_of_run (m_last_of_run)
    );

    // a packet never ends in the middle of a command's byte run
    `DSI_ASSERT_IMP(a_end_is_last, m_valid && m_packet_end, m_last_of_run)
    // a short packet abandons any pending payload
    `DSI_ASSERT_NEXT(a_short_clears, s_valid && s_ready && s_cmd == CMD_SHORT, rem_zero)
    // payload bytes outside a long packet make no job
    `DSI_ASSERT_IMP(a_stray_dropped, s_valid && s_ready && s_cmd == CMD_PAYLOAD && rem_zero, !fifo_push)
    // jobs enter the queue only with an accepted word
    `DSI_ASSERT_IMP(a_push_on_accept, fifo_push, s_valid && s_ready)

endmodule
